// File: rtl/i64div_pkg.sv
// Shared types and constants for the 64-bit integer divider.
`default_nettype none

package i64div_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned OP_W   = 2;
    localparam int unsigned CNT_W  = 6;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SDIV = 2'd0;
    localparam logic [OP_W-1:0] OP_SREM = 2'd1;
    localparam logic [OP_W-1:0] OP_UDIV = 2'd2;
    localparam logic [OP_W-1:0] OP_UREM = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // latch operands on an input transfer
        logic prep;     // turn signed operands into magnitudes
        logic step;     // one restoring iteration
        logic fix;      // sign fix-up and result load
    } div_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic zero_div;
    } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/i64div_ctrl.sv
// Controller state machine for the 64-bit integer divider.
`default_nettype none

module i64div_ctrl
    import i64div_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire div_stat_t stat,
    output div_cmd_t       cmd,
    output logic           busy,
    output logic           done
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_ITER = 3'd2;
    localparam logic [2:0] ST_FIX  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
                cnt_next = '0;
                // skip the iterations on a zero divisor
                state_next = stat.zero_div ? ST_FIX : ST_ITER;
            end
            ST_ITER:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == {CNT_W{1'b1}})
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

`default_nettype wire

// File: rtl/i64div_dp.sv
// Datapath of the 64-bit integer divider: operand registers, restoring step, fix-up.
`default_nettype none

module i64div_dp
    import i64div_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [OP_W-1:0]   opcode,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    input  wire div_cmd_t          cmd,
    output div_stat_t              stat,
    output logic [DATA_W-1:0]      result,
    output logic                   div_by_zero
);

    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] aq_reg;    // dividend bits shift out, quotient bits shift in
    logic [DATA_W-1:0] d_reg;
    logic [DATA_W-1:0] rem_reg;
    logic              a_neg_reg, b_neg_reg, zero_reg;
    logic [DATA_W-1:0] result_reg;
    logic              dbz_reg;

    logic              signed_op;
    logic [DATA_W-1:0] rem_sh;
    logic [DATA_W:0]   diff;
    logic              take;
    logic [DATA_W-1:0] quo_fix, rem_fix;

    assign signed_op = (op_reg == OP_SDIV) || (op_reg == OP_SREM);

    // one restoring step: 65-bit partial remainder minus divisor
    assign rem_sh = {rem_reg[DATA_W-2:0], aq_reg[DATA_W-1]};
    assign diff   = {rem_reg[DATA_W-1], rem_sh} - {1'b0, d_reg};
    assign take   = ~diff[DATA_W];

    assign quo_fix = (signed_op && (a_neg_reg != b_neg_reg)) ? (~aq_reg + 1'b1) : aq_reg;
    assign rem_fix = (signed_op && a_neg_reg) ? (~rem_reg + 1'b1) : rem_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            aq_reg   <= dividend;
            d_reg    <= divisor;
            zero_reg <= (divisor == '0);
        end
        else if (cmd.prep)
        begin
            a_neg_reg <= signed_op && aq_reg[DATA_W-1];
            b_neg_reg <= signed_op && d_reg[DATA_W-1];
            rem_reg   <= '0;
            if (signed_op && aq_reg[DATA_W-1])
            begin
                aq_reg <= ~aq_reg + 1'b1;
            end
            if (signed_op && d_reg[DATA_W-1])
            begin
                d_reg <= ~d_reg + 1'b1;
            end
        end
        else if (cmd.step)
        begin
            rem_reg <= take ? diff[DATA_W-1:0] : rem_sh;
            aq_reg  <= {aq_reg[DATA_W-2:0], take};
        end
        else if (cmd.fix)
        begin
            dbz_reg <= zero_reg;
            if (zero_reg)
            begin
                result_reg <= '0;
            end
            else if ((op_reg == OP_SDIV) || (op_reg == OP_UDIV))
            begin
                result_reg <= quo_fix;
            end
            else
            begin
                result_reg <= rem_fix;
            end
        end
    end

    assign stat.zero_div = zero_reg;
    assign result        = result_reg;
    assign div_by_zero   = dbz_reg;

endmodule

`default_nettype wire

// File: rtl/int64_signed_unsigned_divider.sv
// Top level of the 64-bit signed/unsigned integer divider.
`default_nettype none

// 64-bit integer divider, signed or unsigned, quotient or remainder by opcode
// (0 signed quotient, 1 signed remainder, 2 unsigned quotient, 3 unsigned
// remainder). Raise start with the operands while busy is low; that edge is the
// input transfer, and busy stays high until the result is out. The result and
// div_by_zero are presented with done, which is high for exactly one cycle; the
// receiver cannot stall them, so capture them on that cycle. From the input
// transfer to the done cycle an item goes through forming the magnitudes, the
// radix-2 restoring loop (one quotient bit per cycle through a single 65-bit
// subtractor), the sign fix-up and the done state; a zero divisor skips the
// loop and goes straight to the fix-up, with result zero and div_by_zero set.
// Signed division truncates toward zero, a signed remainder takes the sign of
// the dividend, and the most negative value over minus one wraps to itself.
// The next item may be started in the cycle after done.
module int64_signed_unsigned_divider
    import i64div_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   opcode,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic [DATA_W-1:0]      result,
    output logic                   div_by_zero
);

    div_cmd_t  cmd;
    div_stat_t stat;

    // sequence the work: capture, prep, 64 steps (none on a zero divisor), fix-up, done strobe
    i64div_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // hold the operands and partial remainder, advance one bit per step
    i64div_dp u_dp (
        .clk         (clk),
        .opcode      (opcode),
        .dividend    (dividend),
        .divisor     (divisor),
        .cmd         (cmd),
        .stat        (stat),
        .result      (result),
        .div_by_zero (div_by_zero)
    );

    // an input transfer always makes the block busy next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("input transfer did not raise busy");

    // the done strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // the block stays busy while presenting a result
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // a zero divisor always delivers a zero result
    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_by_zero) |-> (result == '0))
        else $error("nonzero result on divide by zero");

endmodule

`default_nettype wire
